[rtl/msc_pkg.sv]
`default_nettype none

package msc_pkg;

    // Field and register widths fixed by the interface.
    localparam int LEN_W   = 5;
    localparam int STEP_W  = 16;
    localparam int ADDR_W  = 32;
    localparam int IDXIN_W = 4;
    localparam int CFG_W   = 32;
    localparam int CFGI_W  = 2;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_DATA = 1'b1
    } t_op;

    typedef enum logic [CFGI_W-1:0] {
        CFG_PATTERN_LENGTH = 2'd0,
        CFG_STEP_SIZE      = 2'd1,
        CFG_START_ADDRESS  = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } t_result;

endpackage

`default_nettype wire

[rtl/msc_cell.sv]
`default_nettype none

module msc_cell
    import msc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_shift,
    input  wire logic [7:0] i_byte,
    input  wire logic [7:0] i_pat,
    input  wire logic [7:0] i_msk,
    input  wire logic       i_active,
    output logic      [7:0] o_byte,
    output logic            o_hit
);

    logic [7:0] r_byte;

    // The compare looks at the byte this cell takes on the shift, so the
    // window that ends on the arriving byte is judged in the same cycle.
    assign o_hit  = !i_active || (((i_byte ^ i_pat) & i_msk) == 8'h00);
    assign o_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

endmodule

`default_nettype wire

[rtl/msc_outbuf.sv]
`default_nettype none

module msc_outbuf
    import msc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_push_data,
    input  wire logic    i_ready,
    output logic         o_valid,
    output t_result      o_data,
    output logic [1:0]   o_level
);

    logic    r_hd_valid;
    logic    r_sk_valid;
    t_result r_hd;
    t_result r_sk;
    logic    w_pop;

    assign w_pop   = r_hd_valid && i_ready;
    assign o_valid = r_hd_valid;
    assign o_data  = r_hd;
    assign o_level = {1'b0, r_hd_valid} + {1'b0, r_sk_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hd_valid <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_sk_valid) begin
                r_hd       <= r_sk;
                r_sk_valid <= i_push;
                r_sk       <= i_push_data;
            end else begin
                r_hd_valid <= i_push;
                r_hd       <= i_push_data;
            end
        end else if (!r_hd_valid) begin
            r_hd_valid <= i_push;
            r_hd       <= i_push_data;
        end else if (i_push) begin
            r_sk_valid <= 1'b1;
            r_sk       <= i_push_data;
        end
    end

endmodule

`default_nettype wire

[rtl/masked_pattern_scanner.sv]
`default_nettype none

// Masked pattern scanner. Load items fill the pattern and mask entries;
// data items stream the searched range one byte per cycle through a row of
// PAT_MAX byte cells, each of which compares its byte against its pattern
// entry under the mask. One item is taken every clock cycle, loads and data
// alike, unless the input stalls. A scan yields one result, the first
// matching window or not-found on the last byte, which waits after the
// result stage in a two-entry output buffer; the input stalls only while two
// results are still untaken downstream. The user is to write configuration
// through the plain write port while no result is pending; nothing enforces it.
module masked_pattern_scanner
    import msc_pkg::*;
#(
    parameter int PAT_MAX = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CFGI_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_op,
    input  wire logic [IDXIN_W-1:0] i_entry_index,
    input  wire logic [7:0]         i_pattern_byte,
    input  wire logic [7:0]         i_mask_byte,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_last_byte,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_found,
    output logic [ADDR_W-1:0]       o_match_address
);

    localparam int IDX_W = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;

    // Configuration registers.
    logic [LEN_W-1:0]  r_len;
    logic [STEP_W-1:0] r_step;
    logic [ADDR_W-1:0] r_start;

    // Pattern entries; contents are undefined until loaded.
    logic [7:0] r_pat [PAT_MAX];
    logic [7:0] r_msk [PAT_MAX];

    // Scan state.
    logic [ADDR_W-1:0] r_bytes_seen;
    logic [STEP_W-1:0] r_phase;
    logic              r_done;

    // Result stage ahead of the output buffer.
    logic              r_s1_valid;
    logic              r_s1_found;
    logic [ADDR_W-1:0] r_s1_bytes;
    logic [LEN_W-1:0]  r_s1_len;

    logic [LEN_W-1:0]  w_eff_len;
    logic [STEP_W-1:0] w_eff_step;
    logic              w_acc;
    logic              w_load_acc;
    logic              w_data_acc;
    logic              w_go;
    logic              w_tested;
    logic              w_hit;
    logic              w_all_hit;
    logic [ADDR_W-1:0] w_bytes_new;
    logic [STEP_W:0]   w_phase_inc;
    logic [STEP_W-1:0] w_phase_next;
    logic [PAT_MAX-1:0] w_hits;
    logic [7:0]        w_chain [PAT_MAX+1];
    logic [1:0]        w_level;
    logic [1:0]        w_pending;
    logic              w_pop;
    logic              w_buf_valid;
    t_result           w_push_data;
    t_result           w_head;

    assign w_eff_len = (r_len == '0) ? LEN_W'(1) :
                       (32'(r_len) > PAT_MAX) ? LEN_W'(PAT_MAX) : r_len;
    assign w_eff_step = (r_step == '0) ? STEP_W'(1) : r_step;

    assign w_pending  = w_level + {1'b0, r_s1_valid};
    assign w_pop      = w_buf_valid && i_out_ready;
    assign o_in_ready = (w_pending < 2'd2) || ((w_pending == 2'd2) && w_pop);

    assign w_acc      = i_in_valid && o_in_ready;
    assign w_load_acc = w_acc && (i_op == OP_LOAD);
    assign w_data_acc = w_acc && (i_op == OP_DATA);
    assign w_go       = w_data_acc && !r_done;

    assign w_bytes_new = (r_bytes_seen == '1) ? r_bytes_seen : r_bytes_seen + ADDR_W'(1);
    // After this byte, at least eff_len bytes of the scan are in the window.
    assign w_tested  = w_go && (r_bytes_seen >= ADDR_W'(w_eff_len) - ADDR_W'(1));
    assign w_all_hit = &w_hits;
    assign w_hit     = w_tested && (r_phase == '0) && w_all_hit;

    assign w_phase_inc  = {1'b0, r_phase} + (STEP_W+1)'(1);
    assign w_phase_next = (w_phase_inc >= {1'b0, w_eff_step}) ? '0 : w_phase_inc[STEP_W-1:0];

    // Cell k holds the byte k places back in the stream and is compared with
    // pattern entry eff_len-1-k.
    assign w_chain[0] = i_data_byte;

    for (genvar k = 0; k < PAT_MAX; k++) begin : g_cell
        logic [LEN_W-1:0] w_rel;
        logic [IDX_W-1:0] w_sel;
        logic             w_active;

        assign w_rel    = w_eff_len - LEN_W'(1) - LEN_W'(k);
        assign w_sel    = IDX_W'(w_rel);
        assign w_active = int'(w_eff_len) > k;

        msc_cell u_cell (
            .i_clk    (i_clk),
            .i_shift  (w_go),
            .i_byte   (w_chain[k]),
            .i_pat    (r_pat[w_sel]),
            .i_msk    (r_msk[w_sel]),
            .i_active (w_active),
            .o_byte   (w_chain[k+1]),
            .o_hit    (w_hits[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= LEN_W'(1);
            r_step  <= STEP_W'(1);
            r_start <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PATTERN_LENGTH: r_len   <= i_cfg_data[LEN_W-1:0];
                CFG_STEP_SIZE:      r_step  <= i_cfg_data[STEP_W-1:0];
                CFG_START_ADDRESS:  r_start <= i_cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_acc && (32'(i_entry_index) < PAT_MAX)) begin
            r_pat[IDX_W'(i_entry_index)] <= i_pattern_byte;
            r_msk[IDX_W'(i_entry_index)] <= i_mask_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen <= '0;
            r_phase      <= '0;
            r_done       <= 1'b0;
        end else if (w_data_acc && i_last_byte) begin
            r_bytes_seen <= '0;
            r_phase      <= '0;
            r_done       <= 1'b0;
        end else if (w_go) begin
            r_bytes_seen <= w_bytes_new;
            if (w_hit) begin
                r_done <= 1'b1;
            end else if (w_tested) begin
                r_phase <= w_phase_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_go && (w_hit || i_last_byte);
        end
        r_s1_found <= w_hit;
        r_s1_bytes <= w_bytes_new;
        r_s1_len   <= w_eff_len;
    end

    assign w_push_data.found         = r_s1_found;
    assign w_push_data.match_address = r_s1_found ?
        (r_start + r_s1_bytes - ADDR_W'(r_s1_len)) : '0;

    msc_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1_valid),
        .i_push_data (w_push_data),
        .i_ready     (i_out_ready),
        .o_valid     (w_buf_valid),
        .o_data      (w_head),
        .o_level     (w_level)
    );

    assign o_out_valid     = w_buf_valid;
    assign o_found         = w_head.found;
    assign o_match_address = w_head.match_address;

endmodule

`default_nettype wire

[rtl/msc_checker.sv]
`default_nettype none

module msc_checker
    import msc_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_ready,
    input wire logic              i_op,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire logic              o_found,
    input wire logic [ADDR_W-1:0] o_match_address
);

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_found) && $stable(o_match_address))
        else $error("result changed while stalled");

    // A not-found result carries a zero address.
    a_nf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_match_address == '0)
        else $error("not-found result with nonzero address");

    // The input stalls only while results are backed up at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with an empty output");

    // A fresh result follows an accepted data item that passed the result stage.
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |->
            $past(i_in_valid && o_in_ready && (i_op == OP_DATA), 2))
        else $error("result without a data item behind it");

endmodule

bind masked_pattern_scanner msc_checker u_msc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_op            (i_op),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_found         (o_found),
    .o_match_address (o_match_address)
);

`default_nettype wire

[dv/masked_pattern_scanner_tb.sv]
module masked_pattern_scanner_tb;
    import msc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAT_DEPTH = 16;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned ITEMS_PER_SETTING = 50;

    typedef struct {
        t_op                op;
        logic [IDXIN_W-1:0] entry_index;
        logic [7:0]         pattern_byte;
        logic [7:0]         mask_byte;
        logic [7:0]         data_byte;
        logic               last_byte;
    } t_scan_item;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFGI_W-1:0]  i_cfg_index = CFG_PATTERN_LENGTH;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_op = OP_LOAD;
    logic [IDXIN_W-1:0] i_entry_index = '0;
    logic [7:0]         i_pattern_byte = '0;
    logic [7:0]         i_mask_byte = '0;
    logic [7:0]         i_data_byte = '0;
    logic               i_last_byte = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_found;
    logic [ADDR_W-1:0]  o_match_address;

    // Expected search results, oldest first.
    t_result expected_results[$];

    // Predictor copy of the scanner state and registers.
    logic [7:0]  pat_mem [PAT_DEPTH];
    logic [7:0]  mask_mem [PAT_DEPTH];
    logic [7:0]  window_bytes [PAT_DEPTH];
    logic [31:0] seen_count;
    logic [15:0] phase_count;
    logic        match_reported;
    logic [4:0]  cfg_len;
    logic [15:0] cfg_step;
    logic [31:0] cfg_base;

    int unsigned send_idle_pct = 0;
    int unsigned out_stall_pct = 0;
    int unsigned items_sent = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;

    masked_pattern_scanner #(
        .PAT_MAX(PAT_DEPTH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_entry_index   (i_entry_index),
        .i_pattern_byte  (i_pattern_byte),
        .i_mask_byte     (i_mask_byte),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_found         (o_found),
        .o_match_address (o_match_address)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_ready <= (out_stall_pct == 0) || ($urandom_range(0, 99) >= out_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("masked_pattern_scanner regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result found=%b addr=%h with none expected",
                                          o_found, o_match_address));
            end else begin
                want = expected_results.pop_front();
                if (o_found !== want.found) begin
                    report_mismatch($sformatf("found %b, expected %b", o_found, want.found));
                end
                if (o_match_address !== want.match_address) begin
                    report_mismatch($sformatf("match_address %h, expected %h",
                                              o_match_address, want.match_address));
                end
            end
        end
    end

    function automatic int unsigned effective_length();
        if (cfg_len == 5'd0) begin
            return 1;
        end
        if (cfg_len > PAT_DEPTH) begin
            return PAT_DEPTH;
        end
        return cfg_len;
    endfunction

    function automatic int unsigned effective_step();
        return (cfg_step == 16'd0) ? 1 : cfg_step;
    endfunction

    function automatic void clear_scan_state();
        foreach (window_bytes[i]) begin
            window_bytes[i] = 8'h00;
        end
        seen_count = '0;
        phase_count = '0;
        match_reported = 1'b0;
    endfunction

    function automatic void init_predictor();
        foreach (pat_mem[i]) begin
            pat_mem[i] = 8'h00;
            mask_mem[i] = 8'h00;
        end
        clear_scan_state();
        cfg_len = 5'd1;
        cfg_step = 16'd1;
        cfg_base = 32'd0;
    endfunction

    // Advance the predicted scanner state by one accepted item and queue
    // the search result it produces, if any.
    function automatic void predict_item(input t_scan_item it);
        int unsigned len;
        int unsigned stp;
        int unsigned next_phase;
        logic        hit;
        t_result     res;
        if (it.op == OP_LOAD) begin
            pat_mem[it.entry_index] = it.pattern_byte;
            mask_mem[it.entry_index] = it.mask_byte;
            return;
        end
        if (match_reported) begin
            if (it.last_byte) begin
                clear_scan_state();
            end
            return;
        end
        for (int i = PAT_DEPTH - 1; i > 0; i--) begin
            window_bytes[i] = window_bytes[i-1];
        end
        window_bytes[0] = it.data_byte;
        if (seen_count != 32'hFFFF_FFFF) begin
            seen_count = seen_count + 1;
        end
        len = effective_length();
        stp = effective_step();
        if (seen_count >= len) begin
            // The oldest byte of the window lines up with pattern entry 0.
            hit = 1'b1;
            for (int i = 0; i < len; i++) begin
                if ((window_bytes[len-1-i] & mask_mem[i]) != (pat_mem[i] & mask_mem[i])) begin
                    hit = 1'b0;
                end
            end
            if (phase_count == 16'd0 && hit) begin
                res.found = 1'b1;
                res.match_address = cfg_base + (seen_count - 32'(len));
                expected_results.push_back(res);
                if (it.last_byte) begin
                    clear_scan_state();
                end else begin
                    match_reported = 1'b1;
                end
                return;
            end
            next_phase = 32'(phase_count) + 1;
            phase_count = (next_phase >= stp) ? 16'd0 : 16'(next_phase);
        end
        if (it.last_byte) begin
            res.found = 1'b0;
            res.match_address = '0;
            expected_results.push_back(res);
            clear_scan_state();
        end
    endfunction

    function automatic logic [7:0] random_mask();
        case ($urandom_range(0, 7))
            0: begin
                return 8'h00;
            end
            1, 2: begin
                return 8'hFF;
            end
            default: begin
                return 8'($urandom);
            end
        endcase
    endfunction

    function automatic t_scan_item make_load_item(input logic [IDXIN_W-1:0] idx,
                                                  input logic [7:0] pat,
                                                  input logic [7:0] mask);
        t_scan_item it;
        it.op = OP_LOAD;
        it.entry_index = idx;
        it.pattern_byte = pat;
        it.mask_byte = mask;
        it.data_byte = 8'($urandom);
        it.last_byte = 1'($urandom);
        return it;
    endfunction

    function automatic t_scan_item make_data_item(input logic [7:0] data, input logic last);
        t_scan_item it;
        it.op = OP_DATA;
        it.entry_index = IDXIN_W'($urandom);
        it.pattern_byte = 8'($urandom);
        it.mask_byte = 8'($urandom);
        it.data_byte = data;
        it.last_byte = last;
        return it;
    endfunction

    function automatic t_scan_item random_load_item();
        return make_load_item(IDXIN_W'($urandom), 8'($urandom), random_mask());
    endfunction

    // Called at a falling edge; returns at the falling edge after the
    // item was accepted, with valid still high.
    task automatic send_item(input t_scan_item it);
        // Each cycle the sender stays idle with the set probability.
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= it.op;
        i_entry_index <= it.entry_index;
        i_pattern_byte <= it.pattern_byte;
        i_mask_byte <= it.mask_byte;
        i_data_byte <= it.data_byte;
        i_last_byte <= it.last_byte;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        predict_item(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Hold off the sender until every expected result is back, then give
    // the pipeline time to retire items that produce no result.
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [4:0] len, input logic [15:0] stp,
                              input logic [31:0] base);
        wait_for_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_PATTERN_LENGTH;
        i_cfg_data <= CFG_W'(len);
        @(negedge i_clk);
        i_cfg_index <= CFG_STEP_SIZE;
        i_cfg_data <= CFG_W'(stp);
        @(negedge i_clk);
        i_cfg_index <= CFG_START_ADDRESS;
        i_cfg_data <= CFG_W'(base);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_len = len;
        cfg_step = stp;
        cfg_base = base;
    endtask

    task automatic send_bytes(input logic [7:0] data[$]);
        foreach (data[n]) begin
            send_item(make_data_item(data[n], n == data.size() - 1));
        end
    endtask

    // Three-byte pattern with a don't-care middle byte and a half mask at
    // the end. The base address sits just below the wrap point.
    task automatic test_basic_matches();
        set_config(5'd3, 16'd1, 32'hFFFF_FFFE);
        send_item(make_load_item(4'd0, 8'hA5, 8'hFF));
        send_item(make_load_item(4'd1, 8'h00, 8'h00));
        send_item(make_load_item(4'd2, 8'hFF, 8'h0F));
        // Match in the middle, address wraps, trailing byte is ignored.
        send_bytes('{8'h11, 8'h22, 8'hA5, 8'h00, 8'hFF, 8'h99});
        // Range shorter than the pattern.
        send_bytes('{8'hA5, 8'h00});
        // Window that ends on the last byte.
        send_bytes('{8'hA5, 8'h77, 8'h0F});
        // A load in the middle of a scan must not disturb it.
        send_item(make_data_item(8'hA5, 1'b0));
        send_item(make_load_item(4'd1, 8'h5A, 8'h00));
        send_bytes('{8'h12, 8'h2F});
    endtask

    task automatic test_midscan_reconfig();
        send_item(make_data_item(8'h00, 1'b0));
        send_item(make_data_item(8'h01, 1'b0));
        set_config(5'd1, 16'd2, 32'h0000_0100);
        send_bytes('{8'hA5, 8'h00});
    endtask

    task automatic run_scan();
        logic [7:0]  stream_bytes[$];
        int unsigned len;
        int unsigned stp;
        int unsigned scan_len;
        int unsigned slots;
        int unsigned plant_at;
        int unsigned pick;
        int unsigned flip;
        int unsigned style;
        len = effective_length();
        stp = effective_step();
        case ($urandom_range(0, 9))
            0: begin
                scan_len = $urandom_range(1, len);
            end
            1: begin
                scan_len = $urandom_range(len, len + 120);
            end
            default: begin
                scan_len = $urandom_range(len, len + 24);
            end
        endcase
        for (int n = 0; n < scan_len; n++) begin
            stream_bytes.push_back(8'($urandom));
        end
        style = $urandom_range(0, 99);
        if (scan_len >= len && style < 80) begin
            // Plant the pattern at a tested start offset; bits outside the
            // mask stay random.
            slots = (scan_len - len) / stp;
            plant_at = stp * $urandom_range(0, slots);
            for (int i = 0; i < len; i++) begin
                stream_bytes[plant_at+i] = (pat_mem[i] & mask_mem[i])
                                         | (stream_bytes[plant_at+i] & ~mask_mem[i]);
            end
            // Some planted windows get one compared bit flipped.
            if (style >= 60) begin
                pick = $urandom_range(0, len - 1);
                if (mask_mem[pick] != 8'h00) begin
                    do flip = $urandom_range(0, 7); while (!mask_mem[pick][flip]);
                    stream_bytes[plant_at+pick] = stream_bytes[plant_at+pick] ^ (8'h01 << flip);
                end
            end
        end
        for (int n = 0; n < scan_len; n++) begin
            if ($urandom_range(0, 99) < 3) begin
                send_item(random_load_item());
            end
            send_item(make_data_item(stream_bytes[n], n == scan_len - 1));
        end
    endtask

    task automatic test_random_scans();
        int unsigned start_count;
        logic [4:0]  len;
        logic [15:0] stp;
        for (int i = 0; i < PAT_DEPTH; i++) begin
            send_item(make_load_item(IDXIN_W'(i), 8'($urandom), random_mask()));
        end
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    out_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 57;
                    out_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    out_stall_pct = 57;
                end
                default: begin
                    send_idle_pct = 30;
                    out_stall_pct = 30;
                end
            endcase
            for (int slot = 0; slot < 6; slot++) begin
                if (slot == 0) begin
                    set_config(5'd31, 16'hFFFF, 32'hFFFF_FFFF);
                end else if (slot == 1) begin
                    set_config(5'd0, 16'd0, 32'd0);
                end else begin
                    len = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(17, 31))
                                                      : 5'($urandom_range(1, 16));
                    case ($urandom_range(0, 4))
                        0: begin
                            stp = 16'd1;
                        end
                        1: begin
                            stp = 16'($urandom_range(2, 5));
                        end
                        2: begin
                            stp = 16'($urandom_range(6, 40));
                        end
                        default: begin
                            stp = 16'($urandom);
                        end
                    endcase
                    set_config(len, stp, 32'($urandom));
                end
                start_count = items_sent;
                while (items_sent - start_count < ITEMS_PER_SETTING) begin
                    if ($urandom_range(0, 99) < 10) begin
                        send_item(random_load_item());
                    end
                    run_scan();
                end
            end
        end
    endtask

    initial begin
        init_predictor();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_matches();
        test_midscan_reconfig();
        test_random_scans();
        wait_for_idle();
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("masked_pattern_scanner regression: pass");
        end else begin
            $display("masked_pattern_scanner regression: fail");
        end
        $finish;
    end

endmodule
